### hw/rtl/cbts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbts_pkg
// shared types and constants of the can bit timing search block
// ----------------------------------------------------------------------------
package cbts_pkg;

   // field widths
   localparam int RATE_W  = 20;
   localparam int CLK_W   = 32;
   localparam int PRESC_W = 10;
   localparam int SEG1_W  = 4;
   localparam int SEG2_W  = 3;
   localparam int Q_W     = 5;               // quanta per bit, 7..17
   localparam int STEP_W  = Q_W + RATE_W;    // quanta per bit times rate

   // search bounds
   localparam logic [SEG1_W-1:0] SEG1_FIRST = 4'd4;
   localparam logic [SEG1_W-1:0] SEG1_LAST  = 4'd11;
   localparam logic [SEG2_W-1:0] SEG2_FIRST = 3'd2;
   localparam logic [SEG2_W-1:0] SEG2_LAST  = 3'd5;

   localparam logic [CLK_W-1:0] NO_SCORE    = 32'hFFFF_FFFF;
   localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd36_000_000;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_CLOCK_HZ = 1'b0
   } reg_index_type;

   // controller to datapath
   typedef struct packed {
      logic start;   // capture rate and clock, restart loops
      logic setup;   // compute step for current segment pair
      logic scan;    // score one prescaler and advance
   } cbts_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic exact_hit;   // current candidate scores zero
      logic last_p;
      logic last_s1;
      logic last_s2;
   } cbts_status_type;

endpackage

### hw/rtl/can_bit_timing_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_bit_timing_search
// searches segment 2, segment 1 and prescaler for the bit timing whose clock
// product comes closest to the configured peripheral clock
// ----------------------------------------------------------------------------
// search: each segment pair is one setup state followed by a scan over
//   prescalers 1 to PRESCALE_LIMIT-1, and all 32 pairs are searched unless
//   an exact match ends the search early
// requests: one at a time; req_stall stays high from the taken request until
//   its result beat is taken
// reset: synchronous, clears the controller; clock_hz returns to 36000000
// ----------------------------------------------------------------------------
module can_bit_timing_search #(
   parameter int PRESCALE_LIMIT = 1023
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cbts_pkg::RATE_W-1:0]        req_bit_rate,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic                              rsp_exact,
   output logic [cbts_pkg::PRESC_W-1:0]       rsp_prescaler,
   output logic [cbts_pkg::SEG1_W-1:0]        rsp_seg1_quanta,
   output logic [cbts_pkg::SEG2_W-1:0]        rsp_seg2_quanta,
   output logic [cbts_pkg::CLK_W-1:0]         rsp_error_hz,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cbts_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cbts_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cbts_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import cbts_pkg::*;

   cbts_cmd_type    cmd;
   cbts_status_type status;

   logic [CLK_W-1:0] clock_hz_ff;
   reg_index_type    reg_index;
   logic             csr_write;

   // register index is the word address, low two bits are byte offset
   assign reg_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // clock register, only index zero is backed
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_CLOCK_HZ: clock_hz_ff <= csr_pwdata[CLK_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         REG_CLOCK_HZ: csr_prdata = CSR_DATA_W'(clock_hz_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // sequencer: idle, setup per segment pair, scan, hold result
   cbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // counters, running product and best candidate; the clock value is
   // captured with the beat so the search sees one consistent clock
   cbts_datapath #(
      .PRESCALE_LIMIT (PRESCALE_LIMIT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .bit_rate    (req_bit_rate),
      .clock_hz    (clock_hz_ff),
      .found       (rsp_found),
      .exact       (rsp_exact),
      .prescaler   (rsp_prescaler),
      .seg1_quanta (rsp_seg1_quanta),
      .seg2_quanta (rsp_seg2_quanta),
      .error_hz    (rsp_error_hz)
   );

   // no new request while a result is pending
   a_valid_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while result pending");

   // a taken result beat is not repeated
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result beat repeated");

   // exact implies found with zero error
   a_exact_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exact |-> rsp_found && (rsp_error_hz == '0))
      else $error("exact flag inconsistent with error");

   // a miss reports all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_prescaler == '0) && (rsp_error_hz == '0))
      else $error("miss result carries nonzero fields");

endmodule

### hw/rtl/cbts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbts_ctrl
// sequencer of the search: setup per segment pair, scan over prescalers
// ----------------------------------------------------------------------------
module cbts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cbts_pkg::cbts_cmd_type    cmd,
   input  cbts_pkg::cbts_status_type status
);
   import cbts_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   logic      valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      stall_in = stall_ff;
      valid_in = valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
               stall_in = 1'b1;
            end
         end
         ST_SETUP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.exact_hit ||
                (status.last_p && status.last_s1 && status.last_s2)) begin
               state_in = ST_DONE;
               valid_in = 1'b1;
            end else if (status.last_p) begin
               state_in = ST_SETUP;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
               valid_in = 1'b0;
               stall_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            stall_in = 1'b0;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
         valid_ff <= valid_in;
      end
   end

   assign cmd.start = (state_ff == ST_IDLE) && req_valid;
   assign cmd.setup = (state_ff == ST_SETUP);
   assign cmd.scan  = (state_ff == ST_SCAN);

   assign req_stall = stall_ff;
   assign rsp_valid = valid_ff;

   // stall and valid registers track the state
   a_stall_tracks_state: assert property (@(posedge clock) disable iff (reset)
      stall_ff == (state_ff != ST_IDLE))
      else $error("stall out of step with state");

   a_valid_tracks_state: assert property (@(posedge clock) disable iff (reset)
      valid_ff == (state_ff == ST_DONE))
      else $error("valid out of step with state");

   a_setup_then_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SETUP |=> state_ff == ST_SCAN)
      else $error("setup not followed by scan");

endmodule

### hw/rtl/cbts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbts_datapath
// loop counters, running product, error scoring and best-so-far registers
// ----------------------------------------------------------------------------
module cbts_datapath #(
   parameter int PRESCALE_LIMIT = 1023
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cbts_pkg::cbts_cmd_type         cmd,
   output cbts_pkg::cbts_status_type      status,
   input  logic [cbts_pkg::RATE_W-1:0]    bit_rate,
   input  logic [cbts_pkg::CLK_W-1:0]     clock_hz,
   output logic                          found,
   output logic                          exact,
   output logic [cbts_pkg::PRESC_W-1:0]   prescaler,
   output logic [cbts_pkg::SEG1_W-1:0]    seg1_quanta,
   output logic [cbts_pkg::SEG2_W-1:0]    seg2_quanta,
   output logic [cbts_pkg::CLK_W-1:0]     error_hz
);
   import cbts_pkg::*;

   localparam int P_W  = $clog2(PRESCALE_LIMIT);
   localparam int PW   = Q_W + P_W + RATE_W;   // running product width
   localparam logic [P_W-1:0] P_FIRST = P_W'(1);
   localparam logic [P_W-1:0] P_LAST  = P_W'(PRESCALE_LIMIT - 1);

   logic [RATE_W-1:0] rate_ff;
   logic [CLK_W-1:0]  clk_ff;
   logic [P_W-1:0]    p_ff;
   logic [SEG1_W-1:0] s1_ff;
   logic [SEG2_W-1:0] s2_ff;
   logic [STEP_W-1:0] step_ff;
   logic [PW-1:0]     prod_ff;

   logic              have_ff;
   logic [CLK_W-1:0]  best_err_ff;
   logic [P_W-1:0]    best_p_ff;
   logic [SEG1_W-1:0] best_s1_ff;
   logic [SEG2_W-1:0] best_s2_ff;

   logic [Q_W-1:0]    quanta;
   logic [STEP_W-1:0] step_in;
   logic [PW-1:0]     clk_ext;
   logic [PW-1:0]     err;
   logic              better;

   assign quanta  = Q_W'(1) + Q_W'(s1_ff) + Q_W'(s2_ff);
   assign step_in = STEP_W'(quanta) * STEP_W'(rate_ff);

   assign clk_ext = PW'(clk_ff);
   assign err     = (prod_ff >= clk_ext) ? (prod_ff - clk_ext) : (clk_ext - prod_ff);
   assign better  = err < PW'(best_err_ff);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rate_ff <= bit_rate;
         clk_ff  <= clock_hz;
         s1_ff   <= SEG1_FIRST;
         s2_ff   <= SEG2_FIRST;
      end
      if (cmd.setup) begin
         step_ff <= step_in;
         prod_ff <= PW'(step_in);
         p_ff    <= P_FIRST;
      end
      if (cmd.scan) begin
         p_ff    <= p_ff + P_W'(1);
         prod_ff <= prod_ff + PW'(step_ff);
         if (p_ff == P_LAST) begin
            if (s1_ff == SEG1_LAST) begin
               s1_ff <= SEG1_FIRST;
               s2_ff <= s2_ff + SEG2_W'(1);
            end else begin
               s1_ff <= s1_ff + SEG1_W'(1);
            end
         end
      end
   end

   // best so far
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.start) begin
         have_ff <= 1'b0;
      end else if (cmd.scan && better) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         best_err_ff <= NO_SCORE;
         best_p_ff   <= '0;
         best_s1_ff  <= '0;
         best_s2_ff  <= '0;
      end else if (cmd.scan && better) begin
         best_err_ff <= err[CLK_W-1:0];
         best_p_ff   <= p_ff;
         best_s1_ff  <= s1_ff;
         best_s2_ff  <= s2_ff;
      end
   end

   assign status.exact_hit = (err == '0);
   assign status.last_p    = (p_ff == P_LAST);
   assign status.last_s1   = (s1_ff == SEG1_LAST);
   assign status.last_s2   = (s2_ff == SEG2_LAST);

   assign found       = have_ff;
   assign exact       = have_ff && (best_err_ff == '0);
   assign prescaler   = have_ff ? PRESC_W'(best_p_ff) : '0;
   assign seg1_quanta = have_ff ? best_s1_ff : '0;
   assign seg2_quanta = have_ff ? best_s2_ff : '0;
   assign error_hz    = have_ff ? best_err_ff : '0;

   // a kept candidate always beats the no-score mark
   a_best_below_mark: assert property (@(posedge clock) disable iff (reset)
      cmd.scan && better |=> best_err_ff != NO_SCORE)
      else $error("best error not below no-score mark");

   a_scan_advances_p: assert property (@(posedge clock) disable iff (reset)
      cmd.scan && !status.last_p |=> p_ff == $past(p_ff) + P_W'(1))
      else $error("prescaler counter did not advance");

   a_start_clears_have: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> !have_ff)
      else $error("found flag not cleared at start");

endmodule

### sim/tb_can_bit_timing_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_bit_timing_search
// feeds bit rate requests to the bit timing search under several peripheral
// clock settings, predicts the winning prescaler and segment pair by an
// exhaustive search of its own and checks every result beat field by field
// ----------------------------------------------------------------------------
module tb_can_bit_timing_search;
   import cbts_pkg::*;

   localparam int PRESC_LIMIT = 1023;
   localparam int SPARE_INDEX = 1;        // no register lives here
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS = 20;

   // one predicted result beat
   typedef struct packed {
      logic                found;
      logic                exact;
      logic [PRESC_W-1:0]  prescaler;
      logic [SEG1_W-1:0]   seg1_quanta;
      logic [SEG2_W-1:0]   seg2_quanta;
      logic [CLK_W-1:0]    error_hz;
   } timing_pick_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [RATE_W-1:0]     req_bit_rate = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_found;
   logic                  rsp_exact;
   logic [PRESC_W-1:0]    rsp_prescaler;
   logic [SEG1_W-1:0]     rsp_seg1_quanta;
   logic [SEG2_W-1:0]     rsp_seg2_quanta;
   logic [CLK_W-1:0]      rsp_error_hz;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [RATE_W-1:0]     rate_backlog[$];   // requests not yet driven
   timing_pick_type       timing_due[$];     // predictions awaiting a result beat
   logic [CLK_W-1:0]      model_clock_hz = CLOCK_RESET;
   logic                  req_taken = 1'b0;  // request beat accepted at last rising edge
   int                    fail_count = 0;

   can_bit_timing_search #(
      .PRESCALE_LIMIT(PRESC_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_bit_rate(req_bit_rate),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_exact(rsp_exact),
      .rsp_prescaler(rsp_prescaler),
      .rsp_seg1_quanta(rsp_seg1_quanta),
      .rsp_seg2_quanta(rsp_seg2_quanta),
      .rsp_error_hz(rsp_error_hz),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // exhaustive search in the same order as the block: seg2 outer, seg1 middle,
   // prescaler inner; only a strictly smaller error wins, a zero error stops
   function automatic timing_pick_type search_timing(input logic [RATE_W-1:0] rate,
                                                     input logic [CLK_W-1:0] clk_hz);
      timing_pick_type pick;
      logic [63:0]     best;
      logic [63:0]     prod;
      logic [63:0]     diff;
      logic            stop;
      int              s1;
      int              s2;
      int              p;
      pick = '0;
      best = {32'd0, NO_SCORE};
      stop = 1'b0;
      for (s2 = int'(SEG2_FIRST); s2 <= int'(SEG2_LAST) && !stop; s2++) begin
         for (s1 = int'(SEG1_FIRST); s1 <= int'(SEG1_LAST) && !stop; s1++) begin
            for (p = 1; p < PRESC_LIMIT && !stop; p++) begin
               prod = 64'(1 + s1 + s2) * 64'(p) * 64'(rate);
               diff = (prod >= 64'(clk_hz)) ? prod - 64'(clk_hz) : 64'(clk_hz) - prod;
               if (diff < best) begin
                  best = diff;
                  pick.found = 1'b1;
                  pick.prescaler = PRESC_W'(p);
                  pick.seg1_quanta = SEG1_W'(s1);
                  pick.seg2_quanta = SEG2_W'(s2);
                  stop = (diff == 64'd0);
               end
            end
         end
      end
      if (pick.found) begin
         pick.exact = (best == 64'd0);
         pick.error_hz = best[CLK_W-1:0];
      end
      return pick;
   endfunction

   // random bit rate: standard can rates, rates that land on or near a
   // divisor of the clock, and plain noise over all 20 bits
   function automatic logic [RATE_W-1:0] pick_rate(input logic [CLK_W-1:0] clk_hz);
      int unsigned kind;
      int unsigned quanta;
      int unsigned presc;
      logic [63:0] rate;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         case ($urandom_range(0, 8))
            0: rate = 64'd10_000;
            1: rate = 64'd20_000;
            2: rate = 64'd50_000;
            3: rate = 64'd100_000;
            4: rate = 64'd125_000;
            5: rate = 64'd250_000;
            6: rate = 64'd500_000;
            7: rate = 64'd800_000;
            default: rate = 64'd1_000_000;
         endcase
      end else if (kind < 7) begin
         quanta = $urandom_range(7, 17);
         presc = (kind == 4) ? $urandom_range(1, 20) : $urandom_range(1, PRESC_LIMIT - 1);
         rate = 64'(clk_hz) / 64'(quanta * presc);
         // nudge off the exact divisor now and then
         if ($urandom_range(0, 2) == 0)
            rate = rate + 64'(1);
         if (rate > 64'hF_FFFF)
            rate = 64'($urandom_range(0, 32'hF_FFFF));
      end else begin
         rate = 64'($urandom_range(0, 32'hF_FFFF));
      end
      return rate[RATE_W-1:0];
   endfunction

   task automatic csr_write(input int index, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = CSR_ADDR_W'(index * 4);
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (index == int'(REG_CLOCK_HZ))
         model_clock_hz = value;
   endtask

   task automatic csr_check(input int index, input logic [CSR_DATA_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = CSR_ADDR_W'(index * 4);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (got !== want) begin
         $error("clock_hz readback: expected %0d, got %0d", want, got);
         fail_count++;
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // block is idle once every request went out and every result came back;
   // looked at on the rising edge, where the driver's outputs have settled
   task automatic wait_drained();
      do @(posedge clock);
      while (rate_backlog.size() != 0 || req_valid || timing_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // request driver: bursts of random length with random gaps in between
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled beat holds its payload
      end else if (gap_left > 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (rate_backlog.size() != 0) begin
         req_valid <= 1'b1;
         req_bit_rate <= rate_backlog.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 6);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result stall pattern: free-flowing, coin-flip and long blocked runs, with a
   // new mode drawn whenever the low eight bits of the tick counter are zero
   int unsigned stall_tick = 0;
   int unsigned stall_mode = 0;

   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick[7:0] == 8'd0)
         stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= (stall_tick[6:4] != 3'd0);
      endcase
   end

   // monitor: predict on each accepted request beat, check each result beat
   always @(posedge clock) begin
      timing_pick_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            timing_due.push_back(search_timing(req_bit_rate, model_clock_hz));
         if (rsp_valid && !rsp_stall) begin
            if (timing_due.size() == 0) begin
               $error("result beat with no request outstanding");
               fail_count++;
            end else begin
               want = timing_due.pop_front();
               check_field("found", 64'(want.found), 64'(rsp_found));
               check_field("exact", 64'(want.exact), 64'(rsp_exact));
               check_field("prescaler", 64'(want.prescaler), 64'(rsp_prescaler));
               check_field("seg1_quanta", 64'(want.seg1_quanta), 64'(rsp_seg1_quanta));
               check_field("seg2_quanta", 64'(want.seg2_quanta), 64'(rsp_seg2_quanta));
               check_field("error_hz", 64'(want.error_hz), 64'(rsp_error_hz));
            end
         end
      end
   end

   initial begin
      logic [CLK_W-1:0] phase_clock;
      int               k;
      int               n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset clock of 36 mhz: zero rate, field extremes, alternating bits,
      // an exact hit and a few ordinary rates
      csr_check(int'(REG_CLOCK_HZ), CLOCK_RESET);
      rate_backlog = '{20'd0, 20'd1, 20'hF_FFFF, 20'hA_AAAA, 20'h5_5555,
                       20'd1_000_000, 20'd500_000, 20'd125_000, 20'd33_333, 20'd7};
      wait_drained();

      // write to an empty register slot must leave clock_hz alone
      csr_write(SPARE_INDEX, 32'd0);
      csr_check(int'(REG_CLOCK_HZ), CLOCK_RESET);
      rate_backlog = '{20'd125_000};
      wait_drained();

      // zero clock: zero rate is an exact hit on the very first candidate
      csr_write(int'(REG_CLOCK_HZ), 32'd0);
      csr_check(int'(REG_CLOCK_HZ), 32'd0);
      rate_backlog = '{20'd0, 20'd1, 20'hF_FFFF};
      wait_drained();

      // all-ones clock: zero rate finds nothing
      csr_write(int'(REG_CLOCK_HZ), NO_SCORE);
      rate_backlog = '{20'd0, 20'd1, 20'hF_FFFF, 20'h8_0000};
      wait_drained();

      // random phases, each under its own clock
      for (k = 0; k < RANDOM_PHASES; k++) begin
         case (k)
            0: phase_clock = 32'd8_000_000;
            1: phase_clock = 32'd80_000_000;
            2: phase_clock = $urandom;
            3: phase_clock = $urandom_range(1_000_000, 100_000_000);
            default: phase_clock = CLOCK_RESET;
         endcase
         csr_write(int'(REG_CLOCK_HZ), phase_clock);
         for (n = 0; n < PHASE_ITEMS; n++)
            rate_backlog.push_back(pick_rate(phase_clock));
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // full searches are the slowest requests; this allows several times the
   // slowest correct run
   initial begin
      #500_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
